[hw/rtl/cpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_pkg
// Shared types and constants of the camera point projection pipeline.
// ----------------------------------------------------------------------------
package cpp_pkg;

  // Channel payload types
  typedef logic signed [31:0] coord_t;
  typedef logic [3:0]         cfg_idx_t;
  typedef logic [63:0]        cfg_data_t;

  // Register indexes
  localparam cfg_idx_t REG_ROT_A     = 4'd0;
  localparam cfg_idx_t REG_ROT_B     = 4'd1;
  localparam cfg_idx_t REG_ROT_C_POSZ = 4'd2;
  localparam cfg_idx_t REG_POS_XY    = 4'd3;
  localparam cfg_idx_t REG_FOCAL     = 4'd4;
  localparam cfg_idx_t REG_PRINCIPAL = 4'd5;
  localparam cfg_idx_t REG_RAD_NUM   = 4'd6;
  localparam cfg_idx_t REG_RAD_DEN   = 4'd7;

  // Reset values: identity rotation, everything else zero
  localparam logic [63:0] ROT_RESET  = 64'd16384;
  localparam logic [47:0] ROT_C_RESET = 48'd16384;

  // Depth threshold in Q16.16 LSB
  localparam logic signed [36:0] DEPTH_MIN = 37'sd7;
  // Normalized coordinate limit, 8.0 in Q.20
  localparam logic [24:0] NORM_LIMIT = 25'd8388608;
  // Largest ratio magnitude, 256 - 2^-20 in Q.20
  localparam logic signed [28:0] RATIO_SAT = 29'sd268435455;
  // 1.0 in Q.32
  localparam logic signed [60:0] ONE_Q32 = 61'sd4294967296;

  // Fields that travel with an item after the depth is known
  typedef struct packed {
    logic        front;
    logic [31:0] depth;
    logic        sat;
  } carry_t;

  // Side data through the normalizing divider
  typedef struct packed {
    logic        front;
    logic [31:0] depth;
    logic        sign_x;
    logic        sign_y;
    logic        big_x;
    logic        big_y;
  } norm_side_t;

  // Side data through the ratio divider
  typedef struct packed {
    carry_t             cy;
    logic signed [24:0] xn;
    logic signed [24:0] yn;
    logic signed [35:0] tx;
    logic signed [35:0] ty;
    logic               neg;
    logic               num_neg;
    logic               num_zero;
    logic               den_zero;
    logic               big;
  } ratio_side_t;

endpackage

[hw/rtl/cpp_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp channel interfaces
// Valid/ready channels for world points, projected results and register writes.
// ----------------------------------------------------------------------------
interface cpp_in_if;
  logic            valid;
  logic            ready;
  cpp_pkg::coord_t point_x;
  cpp_pkg::coord_t point_y;
  cpp_pkg::coord_t point_z;
  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface cpp_out_if;
  logic            valid;
  logic            ready;
  logic            in_front;
  cpp_pkg::coord_t cam_depth;
  cpp_pkg::coord_t pixel_u;
  cpp_pkg::coord_t pixel_v;
  logic            saturated;
  modport source (output valid, output in_front, output cam_depth, output pixel_u,
                  output pixel_v, output saturated, input ready);
  modport sink   (input valid, input in_front, input cam_depth, input pixel_u,
                  input pixel_v, input saturated, output ready);
endinterface

interface cpp_cfg_if;
  logic               valid;
  logic               ready;
  cpp_pkg::cfg_idx_t  index;
  cpp_pkg::cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/cpp_div_pipe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_div_pipe
// Restoring divider, one quotient bit per register stage, several lanes
// sharing one divisor, with side data and valid carried alongside.
// ----------------------------------------------------------------------------
module cpp_div_pipe #(
  parameter int NL = 1,
  parameter int DW = 36,
  parameter int QB = 25,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [DW-1:0]          div,
  input  logic [NL-1:0][DW-1:0]  rem0,
  input  logic [NL-1:0][QB-1:0]  feed,
  input  logic [SW-1:0]          side_in,
  output logic                   out_valid,
  output logic [NL-1:0][QB-1:0]  quot,
  output logic [SW-1:0]          side_out
);

  logic [NL-1:0][DW-1:0] rem_r  [QB-1];
  logic [DW-1:0]         div_r  [QB-1];
  logic [NL-1:0][QB-1:0] work_r [QB];
  logic [SW-1:0]         side_r [QB];
  logic                  vld_r  [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [NL-1:0][DW-1:0] src_rem;
    logic [NL-1:0][QB-1:0] src_work;
    logic [DW-1:0]         src_div;
    logic [SW-1:0]         src_side;
    logic                  src_vld;
    logic [NL-1:0][DW-1:0] rem_nxt;
    logic [NL-1:0][QB-1:0] work_nxt;

    // Select stage source
    if (k == 0) begin : g_first
      assign src_rem  = rem0;
      assign src_work = feed;
      assign src_div  = div;
      assign src_side = side_in;
      assign src_vld  = in_valid;
    end else begin : g_next
      assign src_rem  = rem_r[k-1];
      assign src_work = work_r[k-1];
      assign src_div  = div_r[k-1];
      assign src_side = side_r[k-1];
      assign src_vld  = vld_r[k-1];
    end

    // Shift in the next dividend bit and subtract when it fits
    for (genvar l = 0; l < NL; l++) begin : g_lane
      logic [DW:0] trial;
      logic        hit;
      assign trial       = {src_rem[l], src_work[l][QB-1]};
      assign hit         = trial >= {1'b0, src_div};
      assign rem_nxt[l]  = hit ? DW'(trial - {1'b0, src_div}) : trial[DW-1:0];
      assign work_nxt[l] = {src_work[l][QB-2:0], hit};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        work_r[k] <= work_nxt;
        side_r[k] <= src_side;
      end
    end

    // Keep remainder and divisor for the following stage
    if (k < QB - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          div_r[k] <= src_div;
        end
      end
    end
  end

  assign out_valid = vld_r[QB-1];
  assign quot      = work_r[QB-1];
  assign side_out  = side_r[QB-1];

endmodule

[hw/rtl/camera_point_projection.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_point_projection
// Pinhole projection of world points with rational radial and tangential
// lens distortion, Q16.16 in and out.
// ----------------------------------------------------------------------------
// Usage:
//  in_chan carries one world point (point_x/y/z, Q16.16) per transaction.
//  out_chan returns one result per point: in_front, cam_depth, pixel_u,
//  pixel_v, saturated. cfg_chan writes register index/data; it is always
//  ready and must only be used while no point is in flight.
//  Throughput: one point per clock while out_chan is not stalled. The pipeline
//  holds the two bit-per-stage dividers (25 stages for the x/y
//  normalization, 28 for the radial ratio) plus 17 arithmetic stages.
//  Stall: the whole pipeline holds while a result waits on out_chan; in_chan
//  keeps taking points whenever the output register is free or being taken.
//  Reset: all stage valids clear, the rotation loads the identity and the
//  other registers clear to zero.
// ----------------------------------------------------------------------------
module camera_point_projection (
  input  logic          clk,
  input  logic          rst_n,
  cpp_in_if.sink        in_chan,
  cpp_out_if.source     out_chan,
  cpp_cfg_if.sink       cfg_chan
);

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    logic signed [31:0] res;
    if (x > 64'sd2147483647) res = 32'sh7fffffff;
    else if (x < -64'sd2147483648) res = 32'sh80000000;
    else res = x[31:0];
    return res;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] x);
    return (x > 64'sd2147483647) || (x < -64'sd2147483648);
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [63:0] rot_a_r, rot_b_r, pos_r, foc_r, pp_r, kn_r, kd_r;
  logic [47:0] rot_c_r;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_a_r <= cpp_pkg::ROT_RESET;
      rot_b_r <= cpp_pkg::ROT_RESET;
      rot_c_r <= cpp_pkg::ROT_C_RESET;
      pos_r   <= '0;
      foc_r   <= '0;
      pp_r    <= '0;
      kn_r    <= '0;
      kd_r    <= '0;
    end else if (cfg_chan.valid && cfg_chan.ready) begin
      unique case (cfg_chan.index)
        cpp_pkg::REG_ROT_A:      rot_a_r <= cfg_chan.data;
        cpp_pkg::REG_ROT_B:      rot_b_r <= cfg_chan.data;
        cpp_pkg::REG_ROT_C_POSZ: rot_c_r <= cfg_chan.data[47:0];
        cpp_pkg::REG_POS_XY:     pos_r   <= cfg_chan.data;
        cpp_pkg::REG_FOCAL:      foc_r   <= cfg_chan.data;
        cpp_pkg::REG_PRINCIPAL:  pp_r    <= cfg_chan.data;
        cpp_pkg::REG_RAD_NUM:    kn_r    <= cfg_chan.data;
        cpp_pkg::REG_RAD_DEN:    kd_r    <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // Register fields
  logic signed [15:0] rot_m [9];
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rot_m[i]     = rot_a_r[16*i +: 16];
      rot_m[4 + i] = rot_b_r[16*i +: 16];
    end
    rot_m[8] = rot_c_r[15:0];
  end

  logic signed [31:0] pos_x, pos_y, pos_z, fx, fy, cx, cy;
  logic signed [15:0] k1, k2, k3, p1, k4, k5, k6, p2;
  assign pos_x = $signed(pos_r[31:0]);
  assign pos_y = $signed(pos_r[63:32]);
  assign pos_z = $signed(rot_c_r[47:16]);
  assign fx    = $signed(foc_r[31:0]);
  assign fy    = $signed(foc_r[63:32]);
  assign cx    = $signed(pp_r[31:0]);
  assign cy    = $signed(pp_r[63:32]);
  assign k1    = $signed(kn_r[15:0]);
  assign k2    = $signed(kn_r[31:16]);
  assign k3    = $signed(kn_r[47:32]);
  assign p1    = $signed(kn_r[63:48]);
  assign k4    = $signed(kd_r[15:0]);
  assign k5    = $signed(kd_r[31:16]);
  assign k6    = $signed(kd_r[47:32]);
  assign p2    = $signed(kd_r[63:48]);

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves when the output register frees up
  // --------------------------------------------------------------------------
  logic out_vld_r;
  logic adv;
  assign adv           = !out_vld_r || out_chan.ready;
  assign in_chan.ready = adv;

  // Stage 1: subtract camera position
  logic               s1_vld_r;
  logic signed [32:0] s1_d_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else if (adv) s1_vld_r <= in_chan.valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d_r[0] <= 33'(in_chan.point_x) - 33'(pos_x);
      s1_d_r[1] <= 33'(in_chan.point_y) - 33'(pos_y);
      s1_d_r[2] <= 33'(in_chan.point_z) - 33'(pos_z);
    end
  end

  // Stage 2: rotation products, column i of R times d
  logic               s2_vld_r;
  logic signed [48:0] s2_p_r [3][3];

  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else if (adv) s2_vld_r <= s1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_p_r[i][0] <= rot_m[i] * s1_d_r[0];
        s2_p_r[i][1] <= rot_m[3 + i] * s1_d_r[1];
        s2_p_r[i][2] <= rot_m[6 + i] * s1_d_r[2];
      end
    end
  end

  // Stage 3: sum and floor-shift to Q16.16
  logic               s3_vld_r;
  logic signed [36:0] s3_pc_r [3];
  logic signed [50:0] s3_sum  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_sum[i] = 51'(s2_p_r[i][0]) + 51'(s2_p_r[i][1]) + 51'(s2_p_r[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else if (adv) s3_vld_r <= s2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) s3_pc_r[i] <= $signed(s3_sum[i][50:14]);
    end
  end

  // Stage 4: depth test, magnitudes and divider setup
  logic        s4_vld_r;
  logic [35:0] s4_ax_r, s4_ay_r, s4_ad_r;
  cpp_pkg::norm_side_t s4_side_r;
  logic [35:0] s4_ax_nxt, s4_ay_nxt;

  assign s4_ax_nxt = s3_pc_r[0][36] ? 36'(-s3_pc_r[0]) : s3_pc_r[0][35:0];
  assign s4_ay_nxt = s3_pc_r[1][36] ? 36'(-s3_pc_r[1]) : s3_pc_r[1][35:0];

  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else if (adv) s4_vld_r <= s3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_ax_r          <= s4_ax_nxt;
      s4_ay_r          <= s4_ay_nxt;
      s4_ad_r          <= s3_pc_r[2][35:0];
      s4_side_r.front  <= s3_pc_r[2] > cpp_pkg::DEPTH_MIN;
      s4_side_r.depth  <= clamp32(64'(s3_pc_r[2]));
      s4_side_r.sign_x <= s3_pc_r[0][36];
      s4_side_r.sign_y <= s3_pc_r[1][36];
      s4_side_r.big_x  <= {5'd0, s4_ax_nxt[35:5]} >= s3_pc_r[2][35:0];
      s4_side_r.big_y  <= {5'd0, s4_ay_nxt[35:5]} >= s3_pc_r[2][35:0];
    end
  end

  // --------------------------------------------------------------------------
  // Normalizing divider: |pc|*2^20 / depth, 25 quotient bits, two lanes
  // --------------------------------------------------------------------------
  logic [1:0][35:0] nd_rem0;
  logic [1:0][24:0] nd_feed, nd_quot;
  logic             nd_vld;
  logic [$bits(cpp_pkg::norm_side_t)-1:0] nd_side_out;
  cpp_pkg::norm_side_t ns;

  assign nd_rem0[0] = {5'd0, s4_ax_r[35:5]};
  assign nd_rem0[1] = {5'd0, s4_ay_r[35:5]};
  assign nd_feed[0] = {s4_ax_r[4:0], 20'd0};
  assign nd_feed[1] = {s4_ay_r[4:0], 20'd0};

  cpp_div_pipe #(
    .NL(2), .DW(36), .QB(25), .SW($bits(cpp_pkg::norm_side_t))
  ) u_norm_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (s4_vld_r),
    .div      (s4_ad_r),
    .rem0     (nd_rem0),
    .feed     (nd_feed),
    .side_in  (s4_side_r),
    .out_valid(nd_vld),
    .quot     (nd_quot),
    .side_out (nd_side_out)
  );

  assign ns = cpp_pkg::norm_side_t'(nd_side_out);

  // P1: clamp normalized coordinates to +-8 and apply sign
  logic               q1_vld_r;
  cpp_pkg::carry_t    q1_cy_r;
  logic signed [24:0] q1_xn_r, q1_yn_r;
  logic               q1_ovx, q1_ovy;
  logic [23:0]        q1_magx, q1_magy;

  assign q1_ovx  = ns.big_x || (nd_quot[0] > cpp_pkg::NORM_LIMIT);
  assign q1_ovy  = ns.big_y || (nd_quot[1] > cpp_pkg::NORM_LIMIT);
  assign q1_magx = q1_ovx ? cpp_pkg::NORM_LIMIT[23:0] : nd_quot[0][23:0];
  assign q1_magy = q1_ovy ? cpp_pkg::NORM_LIMIT[23:0] : nd_quot[1][23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) q1_vld_r <= 1'b0;
    else if (adv) q1_vld_r <= nd_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q1_cy_r.front <= ns.front;
      q1_cy_r.depth <= ns.depth;
      q1_cy_r.sat   <= q1_ovx || q1_ovy;
      q1_xn_r <= ns.sign_x ? -$signed({1'b0, q1_magx}) : $signed({1'b0, q1_magx});
      q1_yn_r <= ns.sign_y ? -$signed({1'b0, q1_magy}) : $signed({1'b0, q1_magy});
    end
  end

  // P2: squares and cross product
  logic               q2_vld_r;
  cpp_pkg::carry_t    q2_cy_r;
  logic signed [24:0] q2_xn_r, q2_yn_r;
  logic signed [49:0] q2_xx_r, q2_yy_r, q2_xy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) q2_vld_r <= 1'b0;
    else if (adv) q2_vld_r <= q1_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q2_cy_r <= q1_cy_r;
      q2_xn_r <= q1_xn_r;
      q2_yn_r <= q1_yn_r;
      q2_xx_r <= q1_xn_r * q1_xn_r;
      q2_yy_r <= q1_yn_r * q1_yn_r;
      q2_xy_r <= q1_xn_r * q1_yn_r;
    end
  end

  // P3: r2, xx, yy, xy in Q.20
  logic               q3_vld_r;
  cpp_pkg::carry_t    q3_cy_r;
  logic signed [24:0] q3_xn_r, q3_yn_r;
  logic [27:0]        q3_r2_r;
  logic [26:0]        q3_xx_r, q3_yy_r;
  logic signed [29:0] q3_xy_r;
  logic [47:0]        q3_rsum;

  assign q3_rsum = q2_xx_r[47:0] + q2_yy_r[47:0];

  always_ff @(posedge clk) begin
    if (!rst_n) q3_vld_r <= 1'b0;
    else if (adv) q3_vld_r <= q2_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q3_cy_r <= q2_cy_r;
      q3_xn_r <= q2_xn_r;
      q3_yn_r <= q2_yn_r;
      q3_r2_r <= q3_rsum[47:20];
      q3_xx_r <= q2_xx_r[46:20];
      q3_yy_r <= q2_yy_r[46:20];
      q3_xy_r <= $signed(q2_xy_r[49:20]);
    end
  end

  // P4: r2 squared, tangential sums
  logic               q4_vld_r;
  cpp_pkg::carry_t    q4_cy_r;
  logic signed [24:0] q4_xn_r, q4_yn_r;
  logic [55:0]        q4_r4raw_r;
  logic [27:0]        q4_r2_r;
  logic [28:0]        q4_ta_r, q4_tb_r;
  logic signed [29:0] q4_xy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) q4_vld_r <= 1'b0;
    else if (adv) q4_vld_r <= q3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q4_cy_r    <= q3_cy_r;
      q4_xn_r    <= q3_xn_r;
      q4_yn_r    <= q3_yn_r;
      q4_r4raw_r <= q3_r2_r * q3_r2_r;
      q4_r2_r    <= q3_r2_r;
      q4_ta_r    <= 29'(q3_r2_r) + {1'b0, q3_xx_r, 1'b0};
      q4_tb_r    <= 29'(q3_r2_r) + {1'b0, q3_yy_r, 1'b0};
      q4_xy_r    <= q3_xy_r;
    end
  end

  // P5: r4, and r4 times r2
  logic               q5_vld_r;
  cpp_pkg::carry_t    q5_cy_r;
  logic signed [24:0] q5_xn_r, q5_yn_r;
  logic [63:0]        q5_r6raw_r;
  logic [35:0]        q5_r4_r;
  logic [27:0]        q5_r2_r;
  logic [28:0]        q5_ta_r, q5_tb_r;
  logic signed [29:0] q5_xy_r;
  logic [35:0]        q5_r4_nxt;

  assign q5_r4_nxt = q4_r4raw_r[55:20];

  always_ff @(posedge clk) begin
    if (!rst_n) q5_vld_r <= 1'b0;
    else if (adv) q5_vld_r <= q4_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q5_cy_r    <= q4_cy_r;
      q5_xn_r    <= q4_xn_r;
      q5_yn_r    <= q4_yn_r;
      q5_r6raw_r <= q5_r4_nxt * q4_r2_r;
      q5_r4_r    <= q5_r4_nxt;
      q5_r2_r    <= q4_r2_r;
      q5_ta_r    <= q4_ta_r;
      q5_tb_r    <= q4_tb_r;
      q5_xy_r    <= q4_xy_r;
    end
  end

  // P6: coefficient products
  logic               q6_vld_r;
  cpp_pkg::carry_t    q6_cy_r;
  logic signed [24:0] q6_xn_r, q6_yn_r;
  logic signed [44:0] q6_a1_r, q6_b1_r;
  logic signed [52:0] q6_a2_r, q6_b2_r;
  logic signed [60:0] q6_a3_r, q6_b3_r;
  logic signed [45:0] q6_t1_r, q6_t2_r, q6_t3_r, q6_t4_r;
  logic signed [28:0] q6_r2s;
  logic signed [36:0] q6_r4s;
  logic signed [44:0] q6_r6s;
  logic signed [29:0] q6_tas, q6_tbs;

  assign q6_r2s = $signed({1'b0, q5_r2_r});
  assign q6_r4s = $signed({1'b0, q5_r4_r});
  assign q6_r6s = $signed({1'b0, q5_r6raw_r[63:20]});
  assign q6_tas = $signed({1'b0, q5_ta_r});
  assign q6_tbs = $signed({1'b0, q5_tb_r});

  always_ff @(posedge clk) begin
    if (!rst_n) q6_vld_r <= 1'b0;
    else if (adv) q6_vld_r <= q5_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q6_cy_r <= q5_cy_r;
      q6_xn_r <= q5_xn_r;
      q6_yn_r <= q5_yn_r;
      q6_a1_r <= k1 * q6_r2s;
      q6_a2_r <= k2 * q6_r4s;
      q6_a3_r <= k3 * q6_r6s;
      q6_b1_r <= k4 * q6_r2s;
      q6_b2_r <= k5 * q6_r4s;
      q6_b3_r <= k6 * q6_r6s;
      q6_t1_r <= p1 * q5_xy_r;
      q6_t2_r <= p2 * q6_tas;
      q6_t3_r <= p1 * q6_tbs;
      q6_t4_r <= p2 * q5_xy_r;
    end
  end

  // P7: numerator, denominator and tangential terms
  logic               q7_vld_r;
  cpp_pkg::carry_t    q7_cy_r;
  logic signed [24:0] q7_xn_r, q7_yn_r;
  logic signed [60:0] q7_num_r, q7_den_r;
  logic signed [35:0] q7_tx_r, q7_ty_r;
  logic signed [47:0] q7_txs, q7_tys;

  assign q7_txs = (48'(q6_t1_r) <<< 1) + 48'(q6_t2_r);
  assign q7_tys = 48'(q6_t3_r) + (48'(q6_t4_r) <<< 1);

  always_ff @(posedge clk) begin
    if (!rst_n) q7_vld_r <= 1'b0;
    else if (adv) q7_vld_r <= q6_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q7_cy_r  <= q6_cy_r;
      q7_xn_r  <= q6_xn_r;
      q7_yn_r  <= q6_yn_r;
      q7_num_r <= cpp_pkg::ONE_Q32 + 61'(q6_a1_r) + 61'(q6_a2_r) + q6_a3_r;
      q7_den_r <= cpp_pkg::ONE_Q32 + 61'(q6_b1_r) + 61'(q6_b2_r) + q6_b3_r;
      q7_tx_r  <= $signed(q7_txs[47:12]);
      q7_ty_r  <= $signed(q7_tys[47:12]);
    end
  end

  // P8: ratio setup, magnitudes and special cases
  logic        q8_vld_r;
  logic [59:0] q8_an_r, q8_ad_r;
  cpp_pkg::ratio_side_t q8_side_r;
  logic [59:0] q8_an_nxt, q8_ad_nxt;

  assign q8_an_nxt = q7_num_r[60] ? 60'(-q7_num_r) : q7_num_r[59:0];
  assign q8_ad_nxt = q7_den_r[60] ? 60'(-q7_den_r) : q7_den_r[59:0];

  always_ff @(posedge clk) begin
    if (!rst_n) q8_vld_r <= 1'b0;
    else if (adv) q8_vld_r <= q7_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q8_an_r            <= q8_an_nxt;
      q8_ad_r            <= q8_ad_nxt;
      q8_side_r.cy       <= q7_cy_r;
      q8_side_r.xn       <= q7_xn_r;
      q8_side_r.yn       <= q7_yn_r;
      q8_side_r.tx       <= q7_tx_r;
      q8_side_r.ty       <= q7_ty_r;
      q8_side_r.neg      <= q7_num_r[60] ^ q7_den_r[60];
      q8_side_r.num_neg  <= q7_num_r[60];
      q8_side_r.num_zero <= q7_num_r == '0;
      q8_side_r.den_zero <= q7_den_r == '0;
      q8_side_r.big      <= {8'd0, q8_an_nxt[59:8]} >= q8_ad_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Ratio divider: |num|*2^20 / |den|, 28 quotient bits
  // --------------------------------------------------------------------------
  logic [0:0][59:0] rd_rem0;
  logic [0:0][27:0] rd_feed, rd_quot;
  logic             rd_vld;
  logic [$bits(cpp_pkg::ratio_side_t)-1:0] rd_side_out;
  cpp_pkg::ratio_side_t rs;

  assign rd_rem0[0] = {8'd0, q8_an_r[59:8]};
  assign rd_feed[0] = {q8_an_r[7:0], 20'd0};

  cpp_div_pipe #(
    .NL(1), .DW(60), .QB(28), .SW($bits(cpp_pkg::ratio_side_t))
  ) u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (q8_vld_r),
    .div      (q8_ad_r),
    .rem0     (rd_rem0),
    .feed     (rd_feed),
    .side_in  (q8_side_r),
    .out_valid(rd_vld),
    .quot     (rd_quot),
    .side_out (rd_side_out)
  );

  assign rs = cpp_pkg::ratio_side_t'(rd_side_out);

  // P9: signed ratio with limits
  logic               q9_vld_r;
  cpp_pkg::carry_t    q9_cy_r;
  logic signed [24:0] q9_xn_r, q9_yn_r;
  logic signed [35:0] q9_tx_r, q9_ty_r;
  logic signed [28:0] q9_rad_r;
  logic signed [28:0] q9_rad_nxt;
  logic signed [28:0] q9_q;

  assign q9_q = $signed({1'b0, rd_quot[0]});

  always_comb begin
    priority if (rs.den_zero) begin
      q9_rad_nxt = rs.num_zero ? 29'sd0 :
                   (rs.num_neg ? -cpp_pkg::RATIO_SAT : cpp_pkg::RATIO_SAT);
    end else if (rs.big) begin
      q9_rad_nxt = rs.neg ? -cpp_pkg::RATIO_SAT : cpp_pkg::RATIO_SAT;
    end else begin
      q9_rad_nxt = rs.neg ? -q9_q : q9_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) q9_vld_r <= 1'b0;
    else if (adv) q9_vld_r <= rd_vld;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q9_cy_r.front <= rs.cy.front;
      q9_cy_r.depth <= rs.cy.depth;
      q9_cy_r.sat   <= rs.cy.sat || rs.den_zero || rs.big;
      q9_xn_r       <= rs.xn;
      q9_yn_r       <= rs.yn;
      q9_tx_r       <= rs.tx;
      q9_ty_r       <= rs.ty;
      q9_rad_r      <= q9_rad_nxt;
    end
  end

  // P10: radial term
  logic               q10_vld_r;
  cpp_pkg::carry_t    q10_cy_r;
  logic signed [35:0] q10_tx_r, q10_ty_r;
  logic signed [53:0] q10_xr_r, q10_yr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) q10_vld_r <= 1'b0;
    else if (adv) q10_vld_r <= q9_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q10_cy_r <= q9_cy_r;
      q10_tx_r <= q9_tx_r;
      q10_ty_r <= q9_ty_r;
      q10_xr_r <= q9_xn_r * q9_rad_r;
      q10_yr_r <= q9_yn_r * q9_rad_r;
    end
  end

  // P11: distorted coordinates, clamped to 32 bits
  logic               q11_vld_r;
  cpp_pkg::carry_t    q11_cy_r;
  logic signed [31:0] q11_xd_r, q11_yd_r;
  logic signed [36:0] q11_xs, q11_ys;

  assign q11_xs = 37'($signed(q10_xr_r[53:20])) + 37'(q10_tx_r);
  assign q11_ys = 37'($signed(q10_yr_r[53:20])) + 37'(q10_ty_r);

  always_ff @(posedge clk) begin
    if (!rst_n) q11_vld_r <= 1'b0;
    else if (adv) q11_vld_r <= q10_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q11_cy_r.front <= q10_cy_r.front;
      q11_cy_r.depth <= q10_cy_r.depth;
      q11_cy_r.sat   <= q10_cy_r.sat || ovf32(64'(q11_xs)) || ovf32(64'(q11_ys));
      q11_xd_r       <= clamp32(64'(q11_xs));
      q11_yd_r       <= clamp32(64'(q11_ys));
    end
  end

  // P12: focal scaling
  logic               q12_vld_r;
  cpp_pkg::carry_t    q12_cy_r;
  logic signed [63:0] q12_fu_r, q12_fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) q12_vld_r <= 1'b0;
    else if (adv) q12_vld_r <= q11_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q12_cy_r <= q11_cy_r;
      q12_fu_r <= fx * q11_xd_r;
      q12_fv_r <= fy * q11_yd_r;
    end
  end

  // Output register: add principal point, clamp, mask points behind
  logic               out_front_r, out_sat_r;
  logic signed [31:0] out_depth_r, out_u_r, out_v_r;
  logic signed [44:0] o_us, o_vs;
  logic               o_sat;

  assign o_us  = 45'($signed(q12_fu_r[63:20])) + 45'(cx);
  assign o_vs  = 45'($signed(q12_fv_r[63:20])) + 45'(cy);
  assign o_sat = q12_cy_r.sat || ovf32(64'(o_us)) || ovf32(64'(o_vs));

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (adv) out_vld_r <= q12_vld_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_front_r <= q12_cy_r.front;
      out_depth_r <= q12_cy_r.depth;
      out_u_r     <= q12_cy_r.front ? clamp32(64'(o_us)) : 32'sd0;
      out_v_r     <= q12_cy_r.front ? clamp32(64'(o_vs)) : 32'sd0;
      out_sat_r   <= q12_cy_r.front && o_sat;
    end
  end

  assign out_chan.valid     = out_vld_r;
  assign out_chan.in_front  = out_front_r;
  assign out_chan.cam_depth = out_depth_r;
  assign out_chan.pixel_u   = out_u_r;
  assign out_chan.pixel_v   = out_v_r;
  assign out_chan.saturated = out_sat_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_front_r) |-> (out_u_r == 32'sd0 && out_v_r == 32'sd0 && !out_sat_r))
    else $error("point behind camera with nonzero pixel or flag");

  a_front_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_front_r) |-> (out_depth_r > 32'sd7))
    else $error("in_front set for depth at or below threshold");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable({s1_vld_r, q1_vld_r, q9_vld_r, out_vld_r}))
    else $error("stage valid changed during stall");

endmodule

[tb/camera_point_projection_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_point_projection_test
// Self-checking bench for the point projection pipeline. A driver streams
// world points in bursts and a monitor checks every projected result against
// a fixed-point predictor of the camera model. Several register settings are
// used: the reset values, a plain pinhole camera, a rotated distorting
// camera, a singular distortion denominator, all-ones registers and extreme
// focal, principal point and rotation values.
// ----------------------------------------------------------------------------
module camera_point_projection_test;

  localparam longint I32_MAX  = 64'sd2147483647;
  localparam longint I32_MIN  = -64'sd2147483648;
  localparam longint Q20      = 64'sd1048576;
  localparam longint NORM_LIM = 64'sd8388608;
  localparam longint ONE_Q32L = 64'sd4294967296;
  localparam int     ONE_M    = 65536;
  localparam int     LATENCY  = 80;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     HOLD_CYCLES = 400;
  localparam int     HOLD_AFTER  = 40;
  // Index outside the register map; writes to it must be dropped
  localparam cpp_pkg::cfg_idx_t REG_UNMAPPED = 4'd12;

  typedef struct {
    cpp_pkg::coord_t x;
    cpp_pkg::coord_t y;
    cpp_pkg::coord_t z;
  } world_pt_t;

  typedef struct {
    logic            front;
    cpp_pkg::coord_t depth;
    cpp_pkg::coord_t u;
    cpp_pkg::coord_t v;
    logic            sat;
  } pixel_res_t;

  logic clk;
  logic rst_n;

  cpp_in_if  pt_bus ();
  cpp_out_if res_bus ();
  cpp_cfg_if cfg_bus ();

  camera_point_projection dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (pt_bus),
    .out_chan (res_bus),
    .cfg_chan (cfg_bus)
  );

  // Bench copy of the register file
  logic [63:0] cam_regs [0:7];

  world_pt_t  point_queue [$];
  pixel_res_t expected_pixels [$];

  int  mismatches;
  int  results_seen;
  int  front_seen;
  int  sat_seen;
  int  points_sent;
  int  cfg_writes;
  int  cycles;
  logic pt_took;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint s16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint s32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint clip(longint x, longint lo, longint hi, inout bit sat);
    if (x < lo) begin
      sat = 1'b1;
      return lo;
    end
    if (x > hi) begin
      sat = 1'b1;
      return hi;
    end
    return x;
  endfunction

  // Signed num/den in Q.20 with the magnitude limited below 256
  function automatic longint rad_ratio(longint num, longint den, inout bit sat);
    longint unsigned an, ad, q, rem;
    bit neg;
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    neg = (num < 0) != (den < 0);
    if (ad == 0) begin
      sat = 1'b1;
      if (an == 0) return 0;
      return (num < 0) ? -longint'(cpp_pkg::RATIO_SAT) : longint'(cpp_pkg::RATIO_SAT);
    end
    q = an / ad;
    if (q >= 256) begin
      sat = 1'b1;
      return neg ? -longint'(cpp_pkg::RATIO_SAT) : longint'(cpp_pkg::RATIO_SAT);
    end
    rem = an % ad;
    for (int i = 0; i < 20; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= ad) begin
        rem = rem - ad;
        q   = q | 1;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic pixel_res_t project_point(world_pt_t p);
    longint m [9];
    longint d0, d1, d2, pcx, pcy, pcz;
    longint xn, yn, xx, yy, xy, r2, r4, r6, num, den, rad, xd, yd, u, v;
    longint fx, fy, cx, cy, k1, k2, k3, k4, k5, k6, p1, p2;
    bit sat;
    pixel_res_t r;
    sat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      m[i]     = s16(cam_regs[cpp_pkg::REG_ROT_A][16*i +: 16]);
      m[4 + i] = s16(cam_regs[cpp_pkg::REG_ROT_B][16*i +: 16]);
    end
    m[8] = s16(cam_regs[cpp_pkg::REG_ROT_C_POSZ][15:0]);

    // Translate, then rotate by the transposed matrix
    d0 = longint'(p.x) - s32(cam_regs[cpp_pkg::REG_POS_XY][31:0]);
    d1 = longint'(p.y) - s32(cam_regs[cpp_pkg::REG_POS_XY][63:32]);
    d2 = longint'(p.z) - s32(cam_regs[cpp_pkg::REG_ROT_C_POSZ][47:16]);
    pcx = (m[0] * d0 + m[3] * d1 + m[6] * d2) >>> 14;
    pcy = (m[1] * d0 + m[4] * d1 + m[7] * d2) >>> 14;
    pcz = (m[2] * d0 + m[5] * d1 + m[8] * d2) >>> 14;

    r.front = 1'b0;
    r.depth = cpp_pkg::coord_t'(clip(pcz, I32_MIN, I32_MAX, sat));
    r.u     = '0;
    r.v     = '0;
    r.sat   = 1'b0;
    sat     = 1'b0;
    if (pcz <= longint'(cpp_pkg::DEPTH_MIN)) return r;

    fx = s32(cam_regs[cpp_pkg::REG_FOCAL][31:0]);
    fy = s32(cam_regs[cpp_pkg::REG_FOCAL][63:32]);
    cx = s32(cam_regs[cpp_pkg::REG_PRINCIPAL][31:0]);
    cy = s32(cam_regs[cpp_pkg::REG_PRINCIPAL][63:32]);
    k1 = s16(cam_regs[cpp_pkg::REG_RAD_NUM][15:0]);
    k2 = s16(cam_regs[cpp_pkg::REG_RAD_NUM][31:16]);
    k3 = s16(cam_regs[cpp_pkg::REG_RAD_NUM][47:32]);
    p1 = s16(cam_regs[cpp_pkg::REG_RAD_NUM][63:48]);
    k4 = s16(cam_regs[cpp_pkg::REG_RAD_DEN][15:0]);
    k5 = s16(cam_regs[cpp_pkg::REG_RAD_DEN][31:16]);
    k6 = s16(cam_regs[cpp_pkg::REG_RAD_DEN][47:32]);
    p2 = s16(cam_regs[cpp_pkg::REG_RAD_DEN][63:48]);

    // Normalize by depth, then the radial powers
    xn = clip((pcx * Q20) / pcz, -NORM_LIM, NORM_LIM, sat);
    yn = clip((pcy * Q20) / pcz, -NORM_LIM, NORM_LIM, sat);
    xx = (xn * xn) >>> 20;
    yy = (yn * yn) >>> 20;
    xy = (xn * yn) >>> 20;
    r2 = (xn * xn + yn * yn) >>> 20;
    r4 = (r2 * r2) >>> 20;
    r6 = (r4 * r2) >>> 20;

    num = ONE_Q32L + k1 * r2 + k2 * r4 + k3 * r6;
    den = ONE_Q32L + k4 * r2 + k5 * r4 + k6 * r6;
    rad = rad_ratio(num, den, sat);

    // Radial scale plus tangential terms
    xd = ((xn * rad) >>> 20) + ((2 * p1 * xy + p2 * (r2 + 2 * xx)) >>> 12);
    yd = ((yn * rad) >>> 20) + ((p1 * (r2 + 2 * yy) + 2 * p2 * xy) >>> 12);
    xd = clip(xd, I32_MIN, I32_MAX, sat);
    yd = clip(yd, I32_MIN, I32_MAX, sat);

    u = clip(((fx * xd) >>> 20) + cx, I32_MIN, I32_MAX, sat);
    v = clip(((fy * yd) >>> 20) + cy, I32_MIN, I32_MAX, sat);

    r.front = 1'b1;
    r.u     = cpp_pkg::coord_t'(u);
    r.v     = cpp_pkg::coord_t'(v);
    r.sat   = sat;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, reset, watchdog
  // --------------------------------------------------------------------------
  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               expected_pixels.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report(string msg);
    mismatches++;
    if (mismatches <= 40) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // --------------------------------------------------------------------------
  // Point driver: bursts of random length with random gaps
  // --------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  // Record acceptance and predict the result of each accepted point
  always @(posedge clk) begin
    if (!rst_n) begin
      pt_took <= 1'b0;
    end else begin
      pt_took <= pt_bus.valid && pt_bus.ready;
      if (pt_bus.valid && pt_bus.ready) begin
        world_pt_t p;
        p.x = pt_bus.point_x;
        p.y = pt_bus.point_y;
        p.z = pt_bus.point_z;
        expected_pixels.push_back(project_point(p));
        points_sent++;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      logic busy;
      world_pt_t p;
      busy = pt_bus.valid && !pt_took;
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (point_queue.size() > 0) begin
          p = point_queue.pop_front();
          pt_bus.point_x <= p.x;
          pt_bus.point_y <= p.y;
          pt_bus.point_z <= p.z;
          busy = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      pt_bus.valid <= busy;
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: changing stall patterns plus one long hold-off
  // --------------------------------------------------------------------------
  int stall_mode;
  int mode_left;
  int hold_left;
  bit hold_done;

  // Count the long hold-off in cycles, started once early in the run
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      logic rdy;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(20, 120);
      end
      mode_left--;
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = $urandom_range(0, 1);
        2: rdy = ($urandom_range(0, 7) != 0);
        default: rdy = (cycles % 5) < 2;
      endcase
      if (hold_left > 0) rdy = 1'b0;
      res_bus.ready <= rdy;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      pixel_res_t w;
      results_seen++;
      if (res_bus.in_front) front_seen++;
      if (res_bus.saturated) sat_seen++;
      if (expected_pixels.size() == 0) begin
        report("result with no point outstanding");
      end else begin
        w = expected_pixels.pop_front();
        if (res_bus.in_front !== w.front)
          report($sformatf("in_front got %b want %b", res_bus.in_front, w.front));
        if (res_bus.cam_depth !== w.depth)
          report($sformatf("cam_depth got %h want %h", res_bus.cam_depth, w.depth));
        if (res_bus.pixel_u !== w.u)
          report($sformatf("pixel_u got %h want %h", res_bus.pixel_u, w.u));
        if (res_bus.pixel_v !== w.v)
          report($sformatf("pixel_v got %h want %h", res_bus.pixel_v, w.v));
        if (res_bus.saturated !== w.sat)
          report($sformatf("saturated got %b want %b", res_bus.saturated, w.sat));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic world_pt_t mk(int x, int y, int z);
    world_pt_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Point inside a frustum of roughly 45 degrees, up to max_m metres deep
  function automatic world_pt_t front_point(int max_m);
    int z;
    z = $urandom_range(ONE_M / 4, max_m * ONE_M);
    return mk($urandom_range(0, 2 * z) - z, $urandom_range(0, 2 * z) - z, z);
  endfunction

  function automatic world_pt_t noise_point();
    return mk($urandom, $urandom, $urandom);
  endfunction

  // Mostly well-formed points, some raw noise
  task automatic queue_random(int n, int max_m);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) point_queue.push_back(front_point(max_m));
      else point_queue.push_back(noise_point());
    end
  endtask

  task automatic write_reg(cpp_pkg::cfg_idx_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_writes++;
    if (idx == cpp_pkg::REG_ROT_C_POSZ) cam_regs[idx] = {16'h0, val[47:0]};
    else if (idx <= cpp_pkg::REG_RAD_DEN) cam_regs[idx] = val;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Hold until every point is in and every result has come back
  task automatic drain();
    while (point_queue.size() > 0 || pt_bus.valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] rnd_coef(int mag);
    return 16'($urandom_range(0, 2 * mag) - mag);
  endfunction

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    pt_bus.valid   = 1'b0;
    pt_bus.point_x = '0;
    pt_bus.point_y = '0;
    pt_bus.point_z = '0;
    res_bus.ready  = 1'b0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = cpp_pkg::REG_ROT_A;
    cfg_bus.data   = '0;
    rst_n = 1'b0;
    cycles = 0;
    burst_left = 1;
    gap_left = 0;
    stall_mode = 0;
    mode_left = 0;
    cam_regs[cpp_pkg::REG_ROT_A]      = cpp_pkg::ROT_RESET;
    cam_regs[cpp_pkg::REG_ROT_B]      = cpp_pkg::ROT_RESET;
    cam_regs[cpp_pkg::REG_ROT_C_POSZ] = {16'h0, cpp_pkg::ROT_C_RESET};
    cam_regs[cpp_pkg::REG_POS_XY]     = '0;
    cam_regs[cpp_pkg::REG_FOCAL]      = '0;
    cam_regs[cpp_pkg::REG_PRINCIPAL]  = '0;
    cam_regs[cpp_pkg::REG_RAD_NUM]    = '0;
    cam_regs[cpp_pkg::REG_RAD_DEN]    = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Reset values: identity rotation, zero focal length
    point_queue.push_back(mk(ONE_M, -ONE_M, 3 * ONE_M));
    point_queue.push_back(mk(0, 0, 8));
    point_queue.push_back(mk(0, 0, 7));
    point_queue.push_back(mk(5 * ONE_M, 2 * ONE_M, -ONE_M));
    drain();

    // Plain pinhole camera with mild distortion
    write_reg(cpp_pkg::REG_ROT_A, cpp_pkg::ROT_RESET);
    write_reg(cpp_pkg::REG_ROT_B, cpp_pkg::ROT_RESET);
    write_reg(cpp_pkg::REG_ROT_C_POSZ, 64'h4000);
    write_reg(cpp_pkg::REG_POS_XY, 64'h0);
    write_reg(cpp_pkg::REG_FOCAL, {32'd500 << 16, 32'd520 << 16});
    write_reg(cpp_pkg::REG_PRINCIPAL, {32'd240 << 16, 32'd320 << 16});
    write_reg(cpp_pkg::REG_RAD_NUM, {16'sd20, 16'sd40, -16'sd200, 16'sd400});
    write_reg(cpp_pkg::REG_RAD_DEN, {-16'sd15, 16'sd10, 16'sd20, 16'sd100});
    point_queue.push_back(mk(0, 0, 0));
    point_queue.push_back(mk(0, 0, 7));
    point_queue.push_back(mk(0, 0, 8));
    point_queue.push_back(mk(0, 0, -ONE_M));
    point_queue.push_back(mk(ONE_M, ONE_M, 2 * ONE_M));
    point_queue.push_back(mk(-3 * ONE_M, 2 * ONE_M, 5 * ONE_M));
    point_queue.push_back(mk(32'h7FFFFFFF, 32'h7FFFFFFF, 8));
    point_queue.push_back(mk(32'h80000000, 32'h80000000, 8));
    point_queue.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF));
    point_queue.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000));
    point_queue.push_back(mk(0, 0, 32'h7FFFFFFF));
    queue_random(180, 50);
    drain();

    // Rotated, offset camera with random distortion
    write_reg(cpp_pkg::REG_ROT_A, {rnd_coef(16384), rnd_coef(16384), rnd_coef(16384),
                                   rnd_coef(16384)});
    write_reg(cpp_pkg::REG_ROT_B, {rnd_coef(16384), rnd_coef(16384), rnd_coef(16384),
                                   rnd_coef(16384)});
    write_reg(cpp_pkg::REG_ROT_C_POSZ,
              {16'h0, 32'($urandom_range(0, 20 * ONE_M) - 10 * ONE_M), rnd_coef(16384)});
    write_reg(cpp_pkg::REG_POS_XY, {32'($urandom_range(0, 20 * ONE_M) - 10 * ONE_M),
                                    32'($urandom_range(0, 20 * ONE_M) - 10 * ONE_M)});
    write_reg(cpp_pkg::REG_FOCAL, {32'($urandom_range(200, 1000)) << 16,
                                   32'($urandom_range(200, 1000)) << 16});
    write_reg(cpp_pkg::REG_PRINCIPAL, {32'($urandom_range(0, 600)) << 16,
                                       32'($urandom_range(0, 800)) << 16});
    write_reg(cpp_pkg::REG_RAD_NUM, {rnd_coef(2048), rnd_coef(2048), rnd_coef(2048),
                                     rnd_coef(2048)});
    write_reg(cpp_pkg::REG_RAD_DEN, {rnd_coef(2048), rnd_coef(2048), rnd_coef(2048),
                                     rnd_coef(2048)});
    queue_random(150, 20);
    drain();

    // Singular denominator at unit radius, then a nearly singular one
    write_reg(cpp_pkg::REG_ROT_A, cpp_pkg::ROT_RESET);
    write_reg(cpp_pkg::REG_ROT_B, cpp_pkg::ROT_RESET);
    write_reg(cpp_pkg::REG_ROT_C_POSZ, 64'h4000);
    write_reg(cpp_pkg::REG_POS_XY, 64'h0);
    write_reg(cpp_pkg::REG_RAD_NUM, 64'h0);
    write_reg(cpp_pkg::REG_RAD_DEN, 64'h0000_0000_0000_F000);
    point_queue.push_back(mk(ONE_M, 0, ONE_M));
    point_queue.push_back(mk(-3 * ONE_M, 0, 3 * ONE_M));
    point_queue.push_back(mk(ONE_M, ONE_M, ONE_M));
    queue_random(30, 10);
    drain();
    write_reg(cpp_pkg::REG_RAD_NUM, 64'h0000_0000_0000_F000);
    point_queue.push_back(mk(2 * ONE_M, 0, 2 * ONE_M));
    drain();
    write_reg(cpp_pkg::REG_RAD_NUM, 64'h0);
    write_reg(cpp_pkg::REG_RAD_DEN, 64'h0000_0000_0000_F001);
    point_queue.push_back(mk(ONE_M, 0, ONE_M));
    queue_random(30, 10);
    drain();

    // All-ones registers; upper bits of the z word and an unmapped index
    for (int i = 0; i < 8; i++)
      write_reg(cpp_pkg::cfg_idx_t'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_UNMAPPED, 64'h0123_4567_89AB_CDEF);
    for (int i = 0; i < 80; i++) point_queue.push_back(noise_point());
    drain();

    // Extreme gains, camera z at the bottom of its range
    write_reg(cpp_pkg::REG_ROT_A, {16'h0000, 16'h8000, 16'h0000, 16'h7FFF});
    write_reg(cpp_pkg::REG_ROT_B, {16'h0000, 16'h0000, 16'h7FFF, 16'h0000});
    write_reg(cpp_pkg::REG_ROT_C_POSZ, {16'hA5A5, 32'h80000000, 16'h7FFF});
    write_reg(cpp_pkg::REG_POS_XY, {32'h7FFFFFFF, 32'h80000000});
    write_reg(cpp_pkg::REG_FOCAL, {32'h7FFFFFFF, 32'h7FFFFFFF});
    write_reg(cpp_pkg::REG_PRINCIPAL, {32'h7FFFFFFF, 32'h80000000});
    write_reg(cpp_pkg::REG_RAD_NUM, rnd64());
    write_reg(cpp_pkg::REG_RAD_DEN, rnd64());
    point_queue.push_back(mk(0, 0, 32'h7FFFFFFF));
    point_queue.push_back(mk(0, 0, 32'h80000000));
    for (int i = 0; i < 150; i++) begin
      if ($urandom_range(0, 1)) point_queue.push_back(noise_point());
      else point_queue.push_back(front_point(1000));
    end
    drain();

    $display("%0d points projected over %0d register writes", points_sent, cfg_writes);
    $display("%0d results in front, %0d saturated, %0d mismatches",
             front_seen, sat_seen, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/cpp_pkg.sv
hw/rtl/cpp_ifs.sv
hw/rtl/cpp_div_pipe.sv
hw/rtl/camera_point_projection.sv
tb/camera_point_projection_test.sv
